/* rtl/lbh_pkg.sv */
// Package for the linear bin histogram: sizes, operation and register codes,
// and the packed transaction types used by the bin mapper and the top level.
// Depends on nothing.
package lbh_pkg;

  // Histogram geometry.
  localparam int NUM_BINS     = 100;
  localparam int COUNT_WIDTH  = 32;
  localparam int SAMPLE_WIDTH = 16;

  // Configuration register width and index width.
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Derived widths for the bin mapping.
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int PROD_W = REG_W + BIN_W;
  localparam int STEP_W = $clog2(BIN_W + 1);

  // Widths of the result fields on the ports.
  localparam int IDX_OUT_W = 7;
  localparam int OUT_W     = 32;

  // Operation codes.
  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SPAN = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [REG_W-1:0] MIN_VALUE_RESET  = 16'd0;
  localparam logic [REG_W-1:0] RANGE_SPAN_RESET = 16'hFFFF;

  // Input transaction.
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] sample_value;
    logic [6:0]  bin_select;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [6:0]  bin_index;
    logic [31:0] bin_count;
    logic [31:0] peak_count;
  } result_t;

  // Status from the bin mapper to the sequencer.
  typedef struct packed {
    logic             done;
    logic [BIN_W-1:0] bin;
  } map_status_t;

endpackage

/* rtl/lbh_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the bin count store; depends on nothing.
module lbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/lbh_bin_divider.sv */
// Bin mapper: offsets the sample, scales it by the bin count and divides by
// the span one quotient bit per cycle; a sample out of range skips the divide. Depends on lbh_pkg.
module lbh_bin_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [15:0]               sample,
  input  logic [lbh_pkg::REG_W-1:0] min_value,
  input  logic [lbh_pkg::REG_W-1:0] range_span,
  output lbh_pkg::map_status_t      status
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_DIV  = 2'd2;

  logic [1:0]                        dstate;
  logic                              done;
  logic [lbh_pkg::REG_W-1:0]         diff;
  logic                              below;
  logic [lbh_pkg::REG_W-1:0]         span;
  logic [lbh_pkg::REG_W-1:0]         rem;
  logic [lbh_pkg::BIN_W-1:0]         low_bits;
  logic [lbh_pkg::BIN_W-1:0]         quot;
  logic [lbh_pkg::STEP_W-1:0]        step;

  logic [lbh_pkg::REG_W-1:0]         sample_ext;
  logic [lbh_pkg::PROD_W-1:0]        product;
  logic [lbh_pkg::REG_W:0]           trial;
  logic [lbh_pkg::REG_W:0]           trial_sub;
  logic                              trial_ge;

  // All sample bits take part in the mapping.
  assign sample_ext = lbh_pkg::REG_W'(sample[lbh_pkg::SAMPLE_WIDTH-1:0]);

  // Scaling by the bin count is a constant multiply, registered right after.
  assign product = lbh_pkg::PROD_W'(diff) * lbh_pkg::PROD_W'(lbh_pkg::NUM_BINS);

  // One restoring division step: bring in the next dividend bit and compare.
  assign trial     = {rem, low_bits[lbh_pkg::BIN_W-1]};
  assign trial_sub = trial - {1'b0, span};
  assign trial_ge  = (trial >= {1'b0, span});

  // Sequencing of the mapper.
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (dstate)
        D_IDLE: begin
          if (start) begin
            dstate <= D_MUL;
          end
        end
        D_MUL: begin
          // Below the minimum or at or past the span the bin is known now.
          if (below || (diff >= span)) begin
            done   <= 1'b1;
            dstate <= D_IDLE;
          end else begin
            dstate <= D_DIV;
          end
        end
        D_DIV: begin
          if (step == '0) begin
            done   <= 1'b1;
            dstate <= D_IDLE;
          end
        end
        default: begin
          dstate <= D_IDLE;
        end
      endcase
    end
  end

  // Datapath of the mapper.
  always_ff @(posedge clk) begin
    case (dstate)
      D_IDLE: begin
        if (start) begin
          diff  <= sample_ext - min_value;
          below <= (sample_ext < min_value);
          span  <= (range_span == '0) ? lbh_pkg::REG_W'(1) : range_span;
        end
      end
      D_MUL: begin
        // The quotient is below the bin count, so the high product bits
        // already form a partial remainder smaller than the span.
        rem      <= product[lbh_pkg::PROD_W-1:lbh_pkg::BIN_W];
        low_bits <= product[lbh_pkg::BIN_W-1:0];
        step     <= lbh_pkg::STEP_W'(lbh_pkg::BIN_W - 1);
        if (below) begin
          quot <= '0;
        end else if (diff >= span) begin
          quot <= lbh_pkg::BIN_W'(lbh_pkg::NUM_BINS - 1);
        end else begin
          quot <= '0;
        end
      end
      D_DIV: begin
        rem      <= trial_ge ? trial_sub[lbh_pkg::REG_W-1:0] : trial[lbh_pkg::REG_W-1:0];
        quot     <= lbh_pkg::BIN_W'({quot, trial_ge});
        low_bits <= low_bits << 1;
        step     <= step - lbh_pkg::STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign status.done = done;
  assign status.bin  = quot;

endmodule

/* rtl/linear_bin_histogram.sv */
// Linear bin histogram top level: command sequencer, configuration registers,
// peak tracker and bin valid bits. Depends on lbh_pkg, lbh_ram, lbh_bin_divider.
//
// Usage: a transaction on item is accepted at a clock edge with start high
// and busy low. Operation accumulate maps sample_value to a bin, bumps that
// bin's saturating count and updates the peak; read returns one bin; clear
// zeroes all bins and the peak; the unused code returns the current peak.
// Each transaction gives exactly one result, shown on result for one cycle
// while done is high. The receiver cannot stall, so results are never held.
// An accumulate passes through the subtract and scale step, the bit-serial
// divider producing one quotient bit per cycle, and the read-modify-write of
// the count RAM; the divider is skipped when the sample lies below min_value
// or at or past min_value plus range_span. A read passes only through the
// read of the count RAM; clear and the unused code are answered straight from
// idle. No new transaction is taken while busy, but one may be accepted in the
// done cycle. Clear and the unused code never raise busy.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 min_value,
// 1 range_span) at once; write only while idle.
// Reset: min_value goes to 0, range_span to 65535, the peak to 0 and every
// bin valid bit is cleared, so all bins read as zero with no clearing pass.
module linear_bin_histogram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lbh_pkg::in_item_t             item,
  output logic                          busy,
  output logic                          done,
  output lbh_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [lbh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbh_pkg::REG_W-1:0]     cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAP    = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_INC    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [lbh_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [2:0]                        state;
  logic [1:0]                        op_reg;
  logic [lbh_pkg::BIN_W-1:0]         addr;
  logic [lbh_pkg::COUNT_WIDTH-1:0]   count_reg;
  logic [lbh_pkg::COUNT_WIDTH-1:0]   peak;
  logic [lbh_pkg::NUM_BINS-1:0]      valid;
  logic [lbh_pkg::REG_W-1:0]         min_value;
  logic [lbh_pkg::REG_W-1:0]         range_span;

  logic                              accept;
  logic                              map_start;
  lbh_pkg::map_status_t              map_status;
  logic [lbh_pkg::BIN_W-1:0]         select_clamped;
  logic [lbh_pkg::COUNT_WIDTH-1:0]   rd_data;
  logic [lbh_pkg::COUNT_WIDTH-1:0]   cur_count;
  logic [lbh_pkg::COUNT_WIDTH-1:0]   count_next;
  logic [lbh_pkg::COUNT_WIDTH-1:0]   peak_next;
  logic                              ram_wr;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign map_start = accept && (item.operation == lbh_pkg::OP_ACCUM);

  // A read beyond the last bin lands on the last bin.
  assign select_clamped = (int'(item.bin_select) >= lbh_pkg::NUM_BINS)
                        ? lbh_pkg::BIN_W'(lbh_pkg::NUM_BINS - 1)
                        : lbh_pkg::BIN_W'(item.bin_select);

  // A bin never written since reset or clear reads as zero.
  assign cur_count  = valid[addr] ? rd_data : '0;
  assign count_next = (cur_count == COUNT_MAX) ? cur_count
                    : cur_count + lbh_pkg::COUNT_WIDTH'(1);

  // Only an accumulate can raise the peak.
  assign peak_next = ((op_reg == lbh_pkg::OP_ACCUM) && (count_reg > peak))
                   ? count_reg : peak;

  assign ram_wr = (state == S_INC) && (op_reg == lbh_pkg::OP_ACCUM);

  lbh_bin_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .start      (map_start),
    .sample     (item.sample_value),
    .min_value  (min_value),
    .range_span (range_span),
    .status     (map_status)
  );

  lbh_ram #(
    .WIDTH (lbh_pkg::COUNT_WIDTH),
    .DEPTH (lbh_pkg::NUM_BINS)
  ) u_counts (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (addr),
    .wr_data (count_next),
    .rd_en   (state == S_READ),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_value  <= lbh_pkg::MIN_VALUE_RESET;
      range_span <= lbh_pkg::RANGE_SPAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbh_pkg::CFG_MIN_VALUE:  min_value  <= cfg_data;
        lbh_pkg::CFG_RANGE_SPAN: range_span <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Command sequencer, peak tracker and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      peak  <= '0;
      valid <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_reg <= item.operation;
            case (item.operation)
              lbh_pkg::OP_ACCUM: begin
                state <= S_MAP;
              end
              lbh_pkg::OP_READ: begin
                addr  <= select_clamped;
                state <= S_READ;
              end
              lbh_pkg::OP_CLEAR: begin
                valid  <= '0;
                peak   <= '0;
                result <= '0;
                done   <= 1'b1;
              end
              default: begin
                result.bin_index  <= '0;
                result.bin_count  <= '0;
                result.peak_count <= lbh_pkg::OUT_W'(peak);
                done              <= 1'b1;
              end
            endcase
          end
        end
        S_MAP: begin
          if (map_status.done) begin
            addr  <= map_status.bin;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_INC;
        end
        S_INC: begin
          if (op_reg == lbh_pkg::OP_ACCUM) begin
            count_reg   <= count_next;
            valid[addr] <= 1'b1;
          end else begin
            count_reg <= cur_count;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          peak              <= peak_next;
          result.bin_index  <= lbh_pkg::IDX_OUT_W'(addr);
          result.bin_count  <= lbh_pkg::OUT_W'(count_reg);
          result.peak_count <= lbh_pkg::OUT_W'(peak_next);
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only ever strobed once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done strobed while busy");

  // Every reported bin is a real bin.
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(result.bin_index) < lbh_pkg::NUM_BINS))
    else $error("result bin index out of range");

  // The peak is never below the count reported with it.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.bin_count <= result.peak_count))
    else $error("bin count above peak");

  // An accepted accumulate keeps the block busy in the next cycle.
  a_accum_busy: assert property (@(posedge clk) disable iff (rst)
    map_start |=> busy)
    else $error("accumulate accepted without going busy");

  // The mapper only finishes while the sequencer waits for it.
  a_map_wait: assert property (@(posedge clk) disable iff (rst)
    map_status.done |-> (state == S_MAP))
    else $error("bin mapper finished outside the map wait");

endmodule
